/* rtl/core/ssfl_pkg.sv */
// Shared types and codes for the safety supervisor with fault log.
// No dependencies; the interfaces and the top level import it.
package ssfl_pkg;

   // Payload widths
   localparam int unsigned COMMAND_W = 3;
   localparam int unsigned CODE_W    = 4;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned SLOT_W    = 4;
   localparam int unsigned MODE_W    = 2;
   localparam int unsigned COUNT_W   = 16;

   // Default ring depth
   localparam int unsigned HISTORY_DEPTH_DEF = 16;

   typedef logic [COMMAND_W-1:0] command_type;
   typedef logic [CODE_W-1:0]    code_type;
   typedef logic [TIME_W-1:0]    time_type;
   typedef logic [SLOT_W-1:0]    slot_type;
   typedef logic [MODE_W-1:0]    mode_type;
   typedef logic [COUNT_W-1:0]   count_type;

   // Commands
   localparam command_type CMD_GO_NORMAL = 3'd0;
   localparam command_type CMD_REPORT    = 3'd1;
   localparam command_type CMD_FORCE     = 3'd2;
   localparam command_type CMD_ACK       = 3'd3;
   localparam command_type CMD_CLEAR     = 3'd4;
   localparam command_type CMD_READ      = 3'd5;

   // Supervisor states
   localparam mode_type MODE_STARTUP = 2'd0;
   localparam mode_type MODE_NORMAL  = 2'd1;
   localparam mode_type MODE_SAFE    = 2'd2;

   // Fault codes with special meaning
   localparam code_type CODE_NONE           = 4'h0;
   localparam code_type CODE_WATCHDOG       = 4'hA;
   localparam code_type CODE_BAD_TRANSITION = 4'hD;
   localparam code_type CODE_RESERVED       = 4'hF;

endpackage

/* rtl/core/ssfl_req_if.sv */
// Request channel of the safety supervisor: valid/ready plus one command.
// Depends on ssfl_pkg for the payload types.
interface ssfl_req_if;
   import ssfl_pkg::*;

   logic        valid;
   logic        ready;
   command_type command;
   code_type    fault_id;
   time_type    stamp_ms;
   slot_type    history_slot;

   modport source (output valid, command, fault_id, stamp_ms, history_slot,
                   input ready);
   modport sink   (input valid, command, fault_id, stamp_ms, history_slot,
                   output ready);
endinterface

/* rtl/core/ssfl_rsp_if.sv */
// Response channel of the safety supervisor: valid/ready plus one status record.
// Depends on ssfl_pkg for the payload types.
interface ssfl_rsp_if;
   import ssfl_pkg::*;

   logic      valid;
   logic      ready;
   logic      accepted;
   mode_type  sup_state;
   code_type  latest_fault;
   logic      pwm_stopped;
   logic      acknowledged;
   count_type total_faults;
   slot_type  next_log_slot;
   code_type  history_fault;
   time_type  history_time;

   modport source (output valid, accepted, sup_state, latest_fault, pwm_stopped,
                   acknowledged, total_faults, next_log_slot, history_fault,
                   history_time,
                   input ready);
   modport sink   (input valid, accepted, sup_state, latest_fault, pwm_stopped,
                   acknowledged, total_faults, next_log_slot, history_fault,
                   history_time,
                   output ready);
endinterface

/* rtl/core/safety_supervisor_fault_log_top.sv */
// Safety supervisor with timestamped fault ring.
// Depends on ssfl_pkg, ssfl_req_if and ssfl_rsp_if.
//
// Usage:
//   req_ch carries one command transaction (go normal, report fault, force
//   safe, acknowledge, clear, read history). rsp_ch returns exactly one status
//   transaction per command: accepted flag, state, last fault, PWM stop,
//   acknowledge, fault count, next ring slot and, for a read, the ring entry.
// Response timing and throughput:
//   The response is registered and appears in the cycle after the command is
//   taken. One command per cycle is sustained while rsp_ch.ready is high: the
//   state update, the ring write and the ring read all complete at the
//   accepting edge, and the ring has one write and one registered read port.
// Stall behavior:
//   A single response register holds the result while rsp_ch.ready is low;
//   req_ch.ready stays high whenever that register is empty or being drained
//   in the same cycle.
// Reset:
//   Synchronous reset returns to startup diagnostics, clears flags, counter
//   and ring pointer, and marks every ring entry unwritten so it reads zero.
//   No clearing pass is needed; the block accepts commands right after reset.
module safety_supervisor_fault_log_top #(
   parameter int unsigned HISTORY_DEPTH = ssfl_pkg::HISTORY_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ssfl_req_if.sink   req_ch,
   ssfl_rsp_if.source rsp_ch
);
   import ssfl_pkg::*;

   localparam int unsigned PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int unsigned IDX_W = (PTR_W > SLOT_W) ? PTR_W : SLOT_W;

   // Supervisor state
   mode_type           mode_ff,         mode_in;
   code_type           recent_fault_ff, recent_fault_in;
   logic               stop_ff,         stop_in;
   logic               ack_ff,          ack_in;
   count_type          fault_tally_ff,  fault_tally_in;
   logic [PTR_W-1:0]   log_ptr_ff,      log_ptr_in;
   logic [HISTORY_DEPTH-1:0] entry_valid_ff;

   // Ring storage
   code_type           log_code_mem [HISTORY_DEPTH];
   time_type           log_time_mem [HISTORY_DEPTH];
   code_type           rd_code_ff;
   time_type           rd_time_ff;

   // Response register
   logic               rsp_valid_ff,    rsp_valid_in;
   logic               accepted_ff,     accepted_in;
   logic               hist_hit_ff,     hist_hit_in;

   // Step decode
   logic               take;
   logic               log_en;
   code_type           log_code;
   logic               slot_ok;
   logic [IDX_W-1:0]   slot_wide;
   logic [PTR_W-1:0]   rd_addr;

   // Accept when the response register is free or draining
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign take         = req_ch.valid && req_ch.ready;

   assign slot_wide = IDX_W'(req_ch.history_slot);
   assign rd_addr   = slot_wide[PTR_W-1:0];
   assign slot_ok   = 32'(req_ch.history_slot) < 32'(HISTORY_DEPTH);

   // Decode one command against the current state
   always_comb begin
      mode_in         = mode_ff;
      recent_fault_in = recent_fault_ff;
      stop_in         = stop_ff;
      ack_in          = ack_ff;
      log_en          = 1'b0;
      log_code        = req_ch.fault_id;
      accepted_in     = 1'b0;
      hist_hit_in     = 1'b0;

      case (req_ch.command)
         CMD_GO_NORMAL: begin
            if (mode_ff == MODE_STARTUP) begin
               mode_in         = MODE_NORMAL;
               recent_fault_in = CODE_NONE;
               accepted_in     = 1'b1;
            end else begin
               log_en   = 1'b1;
               log_code = CODE_BAD_TRANSITION;
            end
         end
         CMD_REPORT: begin
            if (req_ch.fault_id != CODE_NONE && req_ch.fault_id != CODE_RESERVED &&
                (req_ch.fault_id == CODE_WATCHDOG || mode_ff == MODE_NORMAL)) begin
               mode_in         = MODE_SAFE;
               recent_fault_in = req_ch.fault_id;
               stop_in         = 1'b1;
               ack_in          = 1'b0;
               log_en          = 1'b1;
               accepted_in     = 1'b1;
            end
         end
         CMD_FORCE: begin
            mode_in         = MODE_SAFE;
            recent_fault_in = req_ch.fault_id;
            stop_in         = 1'b1;
            ack_in          = 1'b0;
            log_en          = 1'b1;
            accepted_in     = 1'b1;
         end
         CMD_ACK: begin
            ack_in      = 1'b1;
            accepted_in = 1'b1;
         end
         CMD_CLEAR: begin
            if (mode_ff == MODE_SAFE && ack_ff) begin
               mode_in         = MODE_NORMAL;
               recent_fault_in = CODE_NONE;
               stop_in         = 1'b0;
               ack_in          = 1'b0;
               accepted_in     = 1'b1;
            end
         end
         CMD_READ: begin
            if (slot_ok) begin
               accepted_in = 1'b1;
               hist_hit_in = entry_valid_ff[rd_addr];
            end
         end
         default: begin
         end
      endcase
   end

   // Advance ring pointer and counter on a logged fault
   always_comb begin
      log_ptr_in     = log_ptr_ff;
      fault_tally_in = fault_tally_ff;
      if (log_en) begin
         log_ptr_in     = (log_ptr_ff == PTR_W'(HISTORY_DEPTH - 1)) ? '0
                                                                    : log_ptr_ff + 1'b1;
         fault_tally_in = fault_tally_ff + 1'b1;
      end
   end

   // Drop the response once taken, load a new one on accept
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_STARTUP;
         recent_fault_ff <= CODE_NONE;
         stop_ff         <= 1'b0;
         ack_ff          <= 1'b0;
         fault_tally_ff  <= '0;
         log_ptr_ff      <= '0;
         entry_valid_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
         accepted_ff     <= 1'b0;
         hist_hit_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            mode_ff         <= mode_in;
            recent_fault_ff <= recent_fault_in;
            stop_ff         <= stop_in;
            ack_ff          <= ack_in;
            fault_tally_ff  <= fault_tally_in;
            log_ptr_ff      <= log_ptr_in;
            accepted_ff     <= accepted_in;
            hist_hit_ff     <= hist_hit_in;
            if (log_en) begin
               entry_valid_ff[log_ptr_ff] <= 1'b1;
            end
         end
      end
   end

   // Ring write at the pointer, registered read at the requested slot
   always_ff @(posedge clock) begin
      if (take && log_en) begin
         log_code_mem[log_ptr_ff] <= log_code;
         log_time_mem[log_ptr_ff] <= req_ch.stamp_ms;
      end
      if (take && req_ch.command == CMD_READ) begin
         rd_code_ff <= log_code_mem[rd_addr];
         rd_time_ff <= log_time_mem[rd_addr];
      end
   end

   // Response payload straight from state registers
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.accepted      = accepted_ff;
   assign rsp_ch.sup_state     = mode_ff;
   assign rsp_ch.latest_fault  = recent_fault_ff;
   assign rsp_ch.pwm_stopped   = stop_ff;
   assign rsp_ch.acknowledged  = ack_ff;
   assign rsp_ch.total_faults  = fault_tally_ff;
   assign rsp_ch.next_log_slot = SLOT_W'(log_ptr_ff);
   assign rsp_ch.history_fault = hist_hit_ff ? rd_code_ff : CODE_NONE;
   assign rsp_ch.history_time  = hist_hit_ff ? rd_time_ff : '0;

endmodule

/* sim/tb_safety_supervisor_fault_log_top.sv */
// Self-checking testbench for safety_supervisor_fault_log_top: drives command
// transactions and checks every status transaction against a built-in predictor.
// Depends on ssfl_pkg, ssfl_req_if, ssfl_rsp_if and the supervisor top level.
module tb_safety_supervisor_fault_log_top;
   import ssfl_pkg::*;

   localparam int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned DRAIN_CYCLES  = 4;
   localparam int unsigned IDLE_PERCENT  = 31;

   // Command encodings the block does not use
   localparam command_type CMD_UNUSED_LO = 3'd6;
   localparam command_type CMD_UNUSED_HI = 3'd7;

   typedef struct {
      logic      accepted;
      mode_type  sup_state;
      code_type  latest_fault;
      logic      pwm_stopped;
      logic      acknowledged;
      count_type total_faults;
      slot_type  next_slot;
      code_type  hist_fault;
      time_type  hist_time;
   } status_type;

   logic clock;
   logic reset;

   ssfl_req_if req_ch ();
   ssfl_rsp_if rsp_ch ();

   safety_supervisor_fault_log_top #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // Predicted supervisor state
   mode_type  sv_mode;
   code_type  sv_recent;
   logic      sv_stop;
   logic      sv_ack;
   count_type fault_tally;
   code_type  ring_codes [HISTORY_DEPTH];
   time_type  ring_times [HISTORY_DEPTH];
   slot_type  ring_ptr;

   status_type expected_status_q [$];

   // Run control and bookkeeping
   bit sender_idle_en;
   bit receiver_stall_en;
   int hold_off_left;
   int mismatches;
   int commands_sent;
   int status_checked;
   int accepted_count;
   int counter_wraps;
   int ring_wraps;
   int unsigned cycle_count;

   // Clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Timeout watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d status transactions outstanding",
                  cycle_count, expected_status_q.size());
         $display("[safety_supervisor_fault_log_top] ERROR");
         $finish;
      end
   end

   // Write one ring entry and advance pointer and counter
   function automatic void log_fault(code_type code, time_type stamp);
      ring_codes[ring_ptr] = code;
      ring_times[ring_ptr] = stamp;
      if (ring_ptr == slot_type'(HISTORY_DEPTH - 1)) begin
         ring_ptr = '0;
         ring_wraps++;
      end else begin
         ring_ptr = ring_ptr + 1'b1;
      end
      fault_tally = fault_tally + 1'b1;
      if (fault_tally == '0) counter_wraps++;
   endfunction

   // Stop the drive, drop acknowledge and log the fault
   function automatic void go_safe(code_type code, time_type stamp);
      sv_stop   = 1'b1;
      sv_mode   = MODE_SAFE;
      sv_recent = code;
      sv_ack    = 1'b0;
      log_fault(code, stamp);
   endfunction

   // Advance the predicted state by one command and return its status
   function automatic status_type predict_status(command_type cmd, code_type code,
                                                 time_type stamp, slot_type slot);
      status_type s;
      s.accepted   = 1'b0;
      s.hist_fault = CODE_NONE;
      s.hist_time  = '0;
      case (cmd)
         CMD_GO_NORMAL: begin
            if (sv_mode == MODE_STARTUP) begin
               sv_mode    = MODE_NORMAL;
               sv_recent  = CODE_NONE;
               s.accepted = 1'b1;
            end else begin
               log_fault(CODE_BAD_TRANSITION, stamp);
            end
         end
         CMD_REPORT: begin
            if (code != CODE_NONE && code != CODE_RESERVED &&
                (code == CODE_WATCHDOG || sv_mode == MODE_NORMAL)) begin
               go_safe(code, stamp);
               s.accepted = 1'b1;
            end
         end
         CMD_FORCE: begin
            go_safe(code, stamp);
            s.accepted = 1'b1;
         end
         CMD_ACK: begin
            sv_ack     = 1'b1;
            s.accepted = 1'b1;
         end
         CMD_CLEAR: begin
            if (sv_mode == MODE_SAFE && sv_ack) begin
               sv_mode    = MODE_NORMAL;
               sv_recent  = CODE_NONE;
               sv_stop    = 1'b0;
               sv_ack     = 1'b0;
               s.accepted = 1'b1;
            end
         end
         CMD_READ: begin
            if (slot < HISTORY_DEPTH) begin
               s.hist_fault = ring_codes[slot];
               s.hist_time  = ring_times[slot];
               s.accepted   = 1'b1;
            end
         end
         default: ;
      endcase
      s.sup_state    = sv_mode;
      s.latest_fault = sv_recent;
      s.pwm_stopped  = sv_stop;
      s.acknowledged = sv_ack;
      s.total_faults = fault_tally;
      s.next_slot    = ring_ptr;
      return s;
   endfunction

   // Offer one command transaction, wait for it to be taken, record the prediction
   task automatic send_command(command_type cmd, code_type code, time_type stamp,
                               slot_type slot);
      while (sender_idle_en && $urandom_range(99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.command      <= cmd;
      req_ch.fault_id     <= code;
      req_ch.stamp_ms     <= stamp;
      req_ch.history_slot <= slot;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      expected_status_q.push_back(predict_status(cmd, code, stamp, slot));
      if (expected_status_q[$].accepted) accepted_count++;
      commands_sent++;
   endtask

   // Receiver: random stalls, plus a counted hold-off when requested
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_off_left--;
         end else if (receiver_stall_en && $urandom_range(99) < IDLE_PERCENT) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         mismatches++;
      end
   endtask

   // Check each status transaction against the oldest prediction
   always @(posedge clock) begin : check_status
      status_type want;
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_status_q.size() == 0) begin
            $error("status transaction with no command outstanding");
            mismatches++;
         end else begin
            want = expected_status_q.pop_front();
            status_checked++;
            compare_field("accepted",      want.accepted,     rsp_ch.accepted);
            compare_field("sup_state",     want.sup_state,    rsp_ch.sup_state);
            compare_field("latest_fault",  want.latest_fault, rsp_ch.latest_fault);
            compare_field("pwm_stopped",   want.pwm_stopped,  rsp_ch.pwm_stopped);
            compare_field("acknowledged",  want.acknowledged, rsp_ch.acknowledged);
            compare_field("total_faults",  want.total_faults, rsp_ch.total_faults);
            compare_field("next_log_slot", want.next_slot,    rsp_ch.next_log_slot);
            compare_field("history_fault", want.hist_fault,   rsp_ch.history_fault);
            compare_field("history_time",  want.hist_time,    rsp_ch.history_time);
         end
      end
   end

   function automatic code_type pick_code();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 15) return CODE_WATCHDOG;
      if (r < 25) return ($urandom_range(1) != 0) ? CODE_RESERVED : CODE_NONE;
      return code_type'($urandom_range(14, 1));
   endfunction

   function automatic time_type pick_stamp();
      int unsigned r;
      r = $urandom_range(9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return time_type'($urandom);
   endfunction

   // Weighted toward the commands that move the supervisor between states
   function automatic command_type pick_command();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 22) return CMD_REPORT;
      if (r < 32) return CMD_FORCE;
      if (r < 47) return CMD_ACK;
      if (r < 64) return CMD_CLEAR;
      if (r < 72) return CMD_GO_NORMAL;
      if (r < 92) return CMD_READ;
      return ($urandom_range(1) != 0) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
   endfunction

   task automatic send_random(int count);
      repeat (count)
         send_command(pick_command(), pick_code(), pick_stamp(),
                      slot_type'($urandom_range(15)));
   endtask

   // Walk every command and each corner of the state machine once
   task automatic test_directed_transitions();
      send_command(CMD_READ,      CODE_NONE,     32'd0,        4'd3);
      send_command(CMD_REPORT,    4'd5,          32'd100,      4'd0);
      send_command(CMD_GO_NORMAL, CODE_NONE,     32'd200,      4'd0);
      send_command(CMD_GO_NORMAL, CODE_NONE,     32'd300,      4'd0);
      send_command(CMD_REPORT,    CODE_NONE,     32'd400,      4'd0);
      send_command(CMD_REPORT,    CODE_RESERVED, 32'd500,      4'd0);
      send_command(CMD_REPORT,    4'd14,         32'hFFFFFFFF, 4'd0);
      send_command(CMD_REPORT,    4'd4,          32'd600,      4'd0);
      send_command(CMD_FORCE,     CODE_NONE,     32'd0,        4'd0);
      send_command(CMD_FORCE,     CODE_RESERVED, 32'hFFFFFFFF, 4'd0);
      send_command(CMD_REPORT,    CODE_WATCHDOG, 32'hA5A5A5A5, 4'd0);
      send_command(CMD_CLEAR,     CODE_NONE,     32'd700,      4'd0);
      send_command(CMD_ACK,       CODE_NONE,     32'd800,      4'd0);
      send_command(CMD_CLEAR,     CODE_NONE,     32'd900,      4'd0);
      send_command(CMD_CLEAR,     CODE_NONE,     32'd1000,     4'd0);
      send_command(CMD_ACK,       CODE_NONE,     32'd1100,     4'd0);
      send_command(CMD_UNUSED_LO, CODE_WATCHDOG, 32'd1200,     4'd0);
      send_command(CMD_UNUSED_HI, CODE_WATCHDOG, 32'd1300,     4'd0);
      send_command(CMD_READ,      CODE_NONE,     32'd0,        4'd0);
      send_command(CMD_READ,      CODE_NONE,     32'd0,        4'd15);
      send_command(CMD_READ,      CODE_NONE,     32'd0,        4'd5);
      send_command(CMD_REPORT,    CODE_WATCHDOG, 32'd1400,     4'd0);
      send_command(CMD_GO_NORMAL, CODE_NONE,     32'd1500,     4'd0);
   endtask

   // Log faults back to back until the ring wraps, then read every slot
   task automatic test_ring_wrap();
      sender_idle_en    = 1'b0;
      receiver_stall_en = 1'b0;
      repeat (40) begin
         if ($urandom_range(1) != 0)
            send_command(CMD_FORCE, code_type'($urandom_range(15)), pick_stamp(), '0);
         else
            send_command(CMD_GO_NORMAL, CODE_NONE, pick_stamp(), '0);
      end
      for (int i = 0; i < HISTORY_DEPTH; i++)
         send_command(CMD_READ, CODE_NONE, '0, slot_type'(i));
   endtask

   // Random traffic with idling on both sides, then a stretch without, then idling again
   task automatic test_random_traffic();
      sender_idle_en    = 1'b1;
      receiver_stall_en = 1'b1;
      send_random(80);
      sender_idle_en    = 1'b0;
      receiver_stall_en = 1'b0;
      send_random(50);
      sender_idle_en    = 1'b1;
      receiver_stall_en = 1'b1;
      send_random(20);
   endtask

   // Hold the receiver off while commands keep coming, so the input stalls
   task automatic test_backpressure();
      sender_idle_en = 1'b0;
      hold_off_left  = 80;
      send_random(30);
      sender_idle_en = 1'b1;
   endtask

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.command      = CMD_GO_NORMAL;
      req_ch.fault_id     = CODE_NONE;
      req_ch.stamp_ms     = '0;
      req_ch.history_slot = '0;
      sender_idle_en      = 1'b1;
      receiver_stall_en   = 1'b1;
      hold_off_left       = 0;
      cycle_count         = 0;

      // Predicted state after reset
      sv_mode     = MODE_STARTUP;
      sv_recent   = CODE_NONE;
      sv_stop     = 1'b0;
      sv_ack      = 1'b0;
      fault_tally = '0;
      ring_ptr    = '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         ring_codes[i] = CODE_NONE;
         ring_times[i] = '0;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed_transitions();
      test_random_traffic();
      test_backpressure();
      test_ring_wrap();
      test_random_traffic();

      // Drain outstanding status, then give the block time to misbehave
      req_ch.valid <= 1'b0;
      while (expected_status_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d commands (%0d accepted), %0d status transactions checked",
               commands_sent, accepted_count, status_checked);
      $display("Fault counter wrapped %0d time(s), fault ring wrapped %0d time(s)",
               counter_wraps, ring_wraps);
      if (mismatches == 0)
         $display("[safety_supervisor_fault_log_top] OK");
      else
         $display("[safety_supervisor_fault_log_top] ERROR");
      $finish;
   end

endmodule

/* files.f */
rtl/core/ssfl_pkg.sv
rtl/core/ssfl_req_if.sv
rtl/core/ssfl_rsp_if.sv
rtl/core/safety_supervisor_fault_log_top.sv
sim/tb_safety_supervisor_fault_log_top.sv
